// File: design/iate_pkg.sv
// ----------------------------------------------------------------------------
// iate_pkg
// Request and status codes for the integer array table engine.
// ----------------------------------------------------------------------------
package iate_pkg;

  localparam int unsigned ReqW  = 4;
  localparam int unsigned StatW = 2;
  localparam int unsigned WordW = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_READ      = 4'd0,
    REQ_WRITE     = 4'd1,
    REQ_INSERT    = 4'd2,
    REQ_APPEND    = 4'd3,
    REQ_POP_BACK  = 4'd4,
    REQ_POP_FRONT = 4'd5,
    REQ_RESIZE    = 4'd6,
    REQ_ERASE     = 4'd7,
    REQ_SORT      = 4'd8
  } req_t;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

// File: design/iate_ram.sv
// ----------------------------------------------------------------------------
// iate_ram
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iate_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/int_array_table_engine.sv
// ----------------------------------------------------------------------------
// int_array_table_engine
// Ordered store of signed words with a length, run as a sequencer on one RAM.
// ----------------------------------------------------------------------------
// One item at a time. Insert and push back shift each word from the index
// up by one, pop front shifts every word down by one, and a growing resize
// fills the new words with zero. The sort is an insertion sort on the
// single RAM over the range from index to range_end. The result sits in an
// output register, and the next item is taken while it waits.
module int_array_table_engine #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         req_type,
  input  logic [10:0]        index,
  input  logic signed [31:0] value,
  input  logic [10:0]        new_length,
  input  logic [9:0]         range_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [10:0]        length,
  output logic [1:0]         status
);

  import iate_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > 11) ? CW : 11;
  localparam logic [LW-1:0] DepthL = LW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_UP, S_UPW, S_DN, S_DNW, S_FILL,
    S_SI, S_SK, S_SJ, S_SC, S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt, p, lo, hi, tgt, j;
  logic [31:0]   key;
  status_t       res_st;
  logic          req_is_read;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic [LW-1:0] idx_l, cnt_l, nlen_l, rend_l, pos_l;
  logic          is_push;

  iate_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign idx_l    = LW'(index);
  assign cnt_l    = LW'(cnt);
  assign nlen_l   = LW'(new_length);
  assign rend_l   = LW'(range_end);
  assign is_push  = (req_type == REQ_APPEND);
  assign pos_l    = is_push ? cnt_l : idx_l;

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_READ && idx_l < cnt_l) begin
            re    = 1'b1;
            raddr = AW'(index);
          end
          if (req_type == REQ_WRITE && idx_l < cnt_l) begin
            we    = 1'b1;
            waddr = AW'(index);
            wdata = value;
          end
        end
      end
      S_UP: begin
        if (p == lo) begin
          we    = 1'b1;
          waddr = AW'(lo);
          wdata = key;
        end else begin
          re    = 1'b1;
          raddr = AW'(p - 1'b1);
        end
      end
      S_UPW: begin
        we    = 1'b1;
        waddr = AW'(p);
        wdata = rdata;
      end
      S_DN: begin
        if (p != cnt) begin
          re    = 1'b1;
          raddr = AW'(p);
        end
      end
      S_DNW: begin
        we    = 1'b1;
        waddr = AW'(p - 1'b1);
        wdata = rdata;
      end
      S_FILL: begin
        if (p < tgt) begin
          we    = 1'b1;
          waddr = AW'(p);
        end
      end
      S_SI: begin
        if (p <= hi) begin
          re    = 1'b1;
          raddr = AW'(p);
        end
      end
      S_SJ: begin
        if (j == lo) begin
          we    = 1'b1;
          waddr = AW'(j);
          wdata = key;
        end else begin
          re    = 1'b1;
          raddr = AW'(j - 1'b1);
        end
      end
      S_SC: begin
        we    = 1'b1;
        waddr = AW'(j);
        wdata = ($signed(rdata) > $signed(key)) ? rdata : key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_st <= ST_OK;
            state  <= S_DONE;
            case (req_type)
              REQ_READ: begin
                if (idx_l < cnt_l) state <= S_RD;
                else res_st <= ST_BAD;
              end
              REQ_WRITE: begin
                if (!(idx_l < cnt_l)) res_st <= ST_BAD;
              end
              REQ_INSERT, REQ_APPEND: begin
                if (pos_l > cnt_l) begin
                  res_st <= ST_BAD;
                end else if (cnt_l >= DepthL) begin
                  res_st <= ST_FULL;
                end else begin
                  p     <= cnt;
                  lo    <= CW'(pos_l);
                  key   <= value;
                  state <= S_UP;
                end
              end
              REQ_POP_BACK: begin
                if (cnt != '0) cnt <= cnt - 1'b1;
              end
              REQ_POP_FRONT: begin
                if (cnt != '0) begin
                  p     <= CW'(1);
                  state <= S_DN;
                end
              end
              REQ_RESIZE: begin
                if (nlen_l > DepthL) begin
                  res_st <= ST_BAD;
                end else begin
                  p     <= cnt;
                  tgt   <= CW'(nlen_l);
                  state <= S_FILL;
                end
              end
              REQ_ERASE: cnt <= '0;
              REQ_SORT: begin
                if (idx_l <= rend_l && rend_l < cnt_l) begin
                  lo    <= CW'(idx_l);
                  hi    <= CW'(rend_l);
                  p     <= CW'(idx_l) + 1'b1;
                  state <= S_SI;
                end else begin
                  res_st <= ST_BAD;
                end
              end
              default: res_st <= ST_BAD;
            endcase
          end
        end
        S_RD: begin
          state <= S_DONE;
        end
        S_UP: begin
          if (p == lo) begin
            cnt   <= cnt + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_UPW;
          end
        end
        S_UPW: begin
          p     <= p - 1'b1;
          state <= S_UP;
        end
        S_DN: begin
          if (p == cnt) begin
            cnt   <= cnt - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_DNW;
          end
        end
        S_DNW: begin
          p     <= p + 1'b1;
          state <= S_DN;
        end
        S_FILL: begin
          if (p < tgt) begin
            p <= p + 1'b1;
          end else begin
            cnt   <= tgt;
            state <= S_DONE;
          end
        end
        S_SI: begin
          if (p <= hi) state <= S_SK;
          else state <= S_DONE;
        end
        S_SK: begin
          key   <= rdata;
          j     <= p;
          state <= S_SJ;
        end
        S_SJ: begin
          if (j == lo) begin
            p     <= p + 1'b1;
            state <= S_SI;
          end else begin
            state <= S_SC;
          end
        end
        S_SC: begin
          // shift the larger word up, or drop the key into its slot
          if ($signed(rdata) > $signed(key)) begin
            j     <= j - 1'b1;
            state <= S_SJ;
          end else begin
            p     <= p + 1'b1;
            state <= S_SI;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_value <= (res_st == ST_OK && req_is_read) ? rdata : '0;
            length     <= 11'(cnt);
            status     <= res_st;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remembers whether the item in flight is a read, for the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      req_is_read <= 1'b0;
    end else if (state == S_IDLE && in_valid) begin
      req_is_read <= (req_type == REQ_READ);
    end
  end

endmodule
